// ----- rtl/ggc_pkg.sv -----
// Shared constants for the grey Gaussian convolution block.
// Holds parameter defaults, register index codes and coefficient storage sizes.
// No dependencies.
package ggc_pkg;

    localparam int MAX_WIDTH_DEF  = 2048;
    localparam int MAX_HEIGHT_DEF = 4096;
    localparam int MAX_SIDE_DEF   = 5;

    // Configuration register indexes.
    localparam logic [2:0] REG_IMAGE_WIDTH   = 3'd0;
    localparam logic [2:0] REG_IMAGE_HEIGHT  = 3'd1;
    localparam logic [2:0] REG_KERNEL_SIDE   = 3'd2;
    localparam logic [2:0] REG_SCALE_DIVISOR = 3'd3;
    localparam logic [2:0] REG_COEF_BANK0    = 3'd4;
    localparam logic [2:0] REG_COEF_BANK1    = 3'd5;
    localparam logic [2:0] REG_COEF_BANK2    = 3'd6;
    localparam logic [2:0] REG_COEF_BANK3    = 3'd7;

    localparam int NUM_COEF  = 25;
    localparam int COEF_W    = 8;
    localparam int COEF_BITS = NUM_COEF * COEF_W;
    localparam int CFG_W     = 64;
    localparam int DIV_W     = 16;

endpackage

// ----- rtl/ggc_ram.sv -----
// Generic simple dual-port RAM: one write port, one registered read port.
// Used for the grey line store. Depends on nothing.
module ggc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- rtl/ggc_divider.sv -----
// Restoring unsigned divider that retires one quotient bit per cycle.
// Used by the top level to scale each weighted sum. Depends on nothing.
module ggc_divider #(
    parameter int DW = 21,
    parameter int VW = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [DW-1:0] dividend,
    input  logic [VW-1:0] divisor,
    output logic          done,
    output logic [DW-1:0] quotient
);

    localparam int CNT_W = $clog2(DW + 1);

    logic [VW:0]      rem_reg, rem_next;
    logic [DW-1:0]    quo_reg, quo_next;
    logic [VW-1:0]    dvs_reg, dvs_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [VW:0]      trial;

    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg[VW-1:0], quo_reg[DW-1]};
        if (start)
        begin
            rem_next  = '0;
            quo_next  = dividend;
            dvs_next  = divisor;
            cnt_next  = CNT_W'(DW);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, dvs_reg})
            begin
                rem_next = trial - {1'b0, dvs_reg};
                quo_next = {quo_reg[DW-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial;
                quo_next = {quo_reg[DW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ----- rtl/grey_gaussian_convolution.sv -----
// Top level of the grey conversion and square-kernel convolution block.
// Depends on ggc_pkg, ggc_ram (grey line store) and ggc_divider (scaling).
//
//   Channel   Direction  Signals                                   Handshake
//   pixel     in         action, red, green, blue                  pix_valid / pix_ready
//   result    out        blurred_value, out_col, out_row, last_pixel res_valid / res_ready
//   config    in         cfg_index, cfg_data                       cfg_we, no wait
//
// A beat that yields no result leaves the block ready for the next beat. A beat that
// completes a window goes through gather, flush, divide and emit: one line-store read
// per kernel tap on the single read port, then the divider's 21 quotient bits and done.
// Reset clears all control state; the line store needs no clearing since every
// entry a window uses was written first. A result waiting on res_ready does not
// stop the next pixel beat; only the next result waits for the output register.
// Pixel beats are held off during a register write and after it, until the settle
// counter has run down while the derived sizes settle.
module grey_gaussian_convolution #(
    parameter int MAX_WIDTH  = ggc_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = ggc_pkg::MAX_HEIGHT_DEF,
    parameter int MAX_SIDE   = ggc_pkg::MAX_SIDE_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      pix_valid,
    output logic                      pix_ready,
    input  logic                      action,
    input  logic [7:0]                red,
    input  logic [7:0]                green,
    input  logic [7:0]                blue,
    output logic                      res_valid,
    input  logic                      res_ready,
    output logic [7:0]                blurred_value,
    output logic [10:0]               out_col,
    output logic [11:0]               out_row,
    output logic                      last_pixel,
    input  logic                      cfg_we,
    input  logic [2:0]                cfg_index,
    input  logic [ggc_pkg::CFG_W-1:0] cfg_data
);

    localparam int LINE_DEPTH = MAX_SIDE * MAX_WIDTH;
    localparam int AW    = $clog2(LINE_DEPTH);
    localparam int SAW   = AW + 2;
    localparam int WW    = $clog2(MAX_WIDTH + 1);
    localparam int HW    = $clog2(MAX_HEIGHT + 1);
    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int RW    = $clog2(MAX_HEIGHT);
    localparam int POS_W = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
    localparam int LW    = WW + 2;
    localparam int TCW   = WW + 1;
    localparam int TRW   = HW + 1;
    localparam int SUM_W = $clog2(MAX_SIDE * MAX_SIDE * 255 * 255 + 1);
    localparam int KW    = $clog2(ggc_pkg::NUM_COEF);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_GATHER = 5'b00010,
        S_FLUSH  = 5'b00100,
        S_DIVIDE = 5'b01000,
        S_EMIT   = 5'b10000
    } state_t;

    // Configuration registers and values derived from them.
    logic [11:0]                     width_cfg_reg;
    logic [12:0]                     height_cfg_reg;
    logic [2:0]                      side_cfg_reg;
    logic [15:0]                     scale_cfg_reg;
    logic [ggc_pkg::COEF_BITS-1:0]   coef_reg;
    logic [WW-1:0]                   eff_w_reg;
    logic [HW-1:0]                   eff_h_reg;
    logic [2:0]                      side_reg;
    logic [1:0]                      half_reg;
    logic [LW-1:0]                   lead_reg;
    logic [POS_W-1:0]                total_reg;
    logic [ggc_pkg::DIV_W-1:0]       div_reg;
    logic [2:0]                      side_c;
    logic [1:0]                      cfg_settle_reg;

    // Stream control.
    state_t           state_reg, state_next;
    logic [POS_W-1:0] in_pos_reg, in_pos_next;
    logic [POS_W-1:0] out_pos_reg, out_pos_next;
    logic [AW-1:0]    wr_addr_reg, wr_addr_next;
    logic [AW-1:0]    q_addr_reg, q_addr_next;
    logic [CW-1:0]    q_col_reg, q_col_next;
    logic [RW-1:0]    q_row_reg, q_row_next;

    // Tap walk over the kernel window.
    logic [2:0]            tj_reg, tj_next;
    logic [2:0]            ti_reg, ti_next;
    logic [KW-1:0]         k_reg, k_next;
    logic signed [TRW-1:0] tr_reg, tr_next;
    logic signed [TCW-1:0] tc_reg, tc_next;
    logic signed [TCW-1:0] tc0_reg, tc0_next;
    logic [AW-1:0]         tap_addr_reg, tap_addr_next;
    logic                  p_valid_reg, p_valid_next;
    logic                  p_inb_reg, p_inb_next;
    logic [7:0]            p_coef_reg, p_coef_next;
    logic [SUM_W-1:0]      acc_reg, acc_next;

    // Result register.
    logic        res_valid_reg, res_valid_next;
    logic [7:0]  value_reg, value_next;
    logic [10:0] col_reg, col_next;
    logic [11:0] row_reg, row_next;
    logic        last_reg, last_next;

    // Per-beat working values.
    logic             restart;
    logic [POS_W-1:0] ip, op, ip_n;
    logic [AW-1:0]    wa, qa;
    logic [CW-1:0]    qc;
    logic [RW-1:0]    qr;
    logic [9:0]       rgb_sum;
    logic [19:0]      grey_prod;
    logic [7:0]       grey;
    logic             pix_acc;
    logic             pix_drop;
    logic             mem_we;
    logic             win_ready;
    logic             tap_inb;
    logic             last_tap;
    logic [7:0]       rd_data;
    logic             div_done;
    logic [SUM_W-1:0] quotient;

    function automatic logic [AW-1:0] fold_addr(input logic signed [SAW-1:0] x);
        logic signed [SAW-1:0] y;
        y = x;
        if (x < 0)
        begin
            y = x + SAW'(LINE_DEPTH);
        end
        else if (x >= SAW'(LINE_DEPTH))
        begin
            y = x - SAW'(LINE_DEPTH);
        end
        return y[AW-1:0];
    endfunction

    function automatic logic [AW-1:0] ring_inc(input logic [AW-1:0] a);
        return (a == AW'(LINE_DEPTH - 1)) ? '0 : a + 1'b1;
    endfunction

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_cfg_reg  <= 12'd1;
            height_cfg_reg <= 13'd1;
            side_cfg_reg   <= 3'd1;
            scale_cfg_reg  <= 16'd1;
            coef_reg       <= ggc_pkg::COEF_BITS'(1);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                ggc_pkg::REG_IMAGE_WIDTH:   width_cfg_reg  <= cfg_data[11:0];
                ggc_pkg::REG_IMAGE_HEIGHT:  height_cfg_reg <= cfg_data[12:0];
                ggc_pkg::REG_KERNEL_SIDE:   side_cfg_reg   <= cfg_data[2:0];
                ggc_pkg::REG_SCALE_DIVISOR: scale_cfg_reg  <= cfg_data[15:0];
                ggc_pkg::REG_COEF_BANK0:    coef_reg[63:0]    <= cfg_data;
                ggc_pkg::REG_COEF_BANK1:    coef_reg[127:64]  <= cfg_data;
                ggc_pkg::REG_COEF_BANK2:    coef_reg[191:128] <= cfg_data;
                ggc_pkg::REG_COEF_BANK3:    coef_reg[199:192] <= cfg_data[7:0];
                default:                    ;
            endcase
        end
    end

    // Pixel beats wait until this settle counter runs down, while the derived values follow a write.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_settle_reg <= 2'd0;
        end
        else if (cfg_we)
        begin
            cfg_settle_reg <= 2'd2;
        end
        else if (cfg_settle_reg != 2'd0)
        begin
            cfg_settle_reg <= cfg_settle_reg - 2'd1;
        end
    end

    // Effective side: clamped to the maximum, zero taken as one, even lowered by one.
    always_comb
    begin
        side_c = side_cfg_reg;
        if (32'(side_cfg_reg) > MAX_SIDE)
        begin
            side_c = 3'(MAX_SIDE);
        end
        if (side_c == 3'd0)
        begin
            side_c = 3'd1;
        end
        if (!side_c[0])
        begin
            side_c = side_c - 3'd1;
        end
    end

    // Sizes are registered from the configuration registers; lead and total are registered from them in turn.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            eff_w_reg <= WW'(1);
            eff_h_reg <= HW'(1);
            side_reg  <= 3'd1;
            half_reg  <= 2'd0;
            lead_reg  <= '0;
            total_reg <= POS_W'(1);
            div_reg   <= 16'd1;
        end
        else
        begin
            if (width_cfg_reg == 12'd0)
                eff_w_reg <= WW'(1);
            else if (32'(width_cfg_reg) > MAX_WIDTH)
                eff_w_reg <= WW'(MAX_WIDTH);
            else
                eff_w_reg <= WW'(width_cfg_reg);
            if (height_cfg_reg == 13'd0)
                eff_h_reg <= HW'(1);
            else if (32'(height_cfg_reg) > MAX_HEIGHT)
                eff_h_reg <= HW'(MAX_HEIGHT);
            else
                eff_h_reg <= HW'(height_cfg_reg);
            side_reg  <= side_c;
            half_reg  <= side_c[2:1];
            case (half_reg)
                2'd1:    lead_reg <= LW'(eff_w_reg) + LW'(1);
                2'd2:    lead_reg <= LW'({eff_w_reg, 1'b0}) + LW'(2);
                default: lead_reg <= '0;
            endcase
            total_reg <= POS_W'(eff_w_reg) * POS_W'(eff_h_reg);
            div_reg   <= (scale_cfg_reg == 16'd0) ? 16'd1 : scale_cfg_reg;
        end
    end

    // Grey is floor(sum / 3), done as a multiply by 683 / 2048, exact for sums up to 765.
    assign rgb_sum   = 10'(red) + 10'(green) + 10'(blue);
    assign grey_prod = 20'(rgb_sum) * 20'd683;
    assign grey      = grey_prod[18:11];

    // A new image starts when the positions ran past the current image size.
    assign restart = (out_pos_reg >= total_reg) || (in_pos_reg > total_reg);
    assign ip      = restart ? '0 : in_pos_reg;
    assign op      = restart ? '0 : out_pos_reg;
    assign wa      = restart ? '0 : wr_addr_reg;
    assign qa      = restart ? '0 : q_addr_reg;
    assign qc      = restart ? '0 : q_col_reg;
    assign qr      = restart ? '0 : q_row_reg;

    // A pixel that arrives after the whole image is dropped and releases no output.
    assign pix_acc   = pix_valid && pix_ready;
    assign pix_drop  = !action && (ip >= total_reg);
    assign mem_we    = pix_acc && !action && (ip < total_reg);
    assign ip_n      = mem_we ? ip + 1'b1 : ip;
    assign win_ready = !pix_drop && ((ip_n >= total_reg)
                    || ((POS_W + 1)'(ip_n) > (POS_W + 1)'(op) + (POS_W + 1)'(lead_reg)));

    assign tap_inb  = (tr_reg >= 0) && (tr_reg < $signed(TRW'(eff_h_reg)))
                   && (tc_reg >= 0) && (tc_reg < $signed(TCW'(eff_w_reg)));
    assign last_tap = (tj_reg == side_reg - 3'd1) && (ti_reg == side_reg - 3'd1);

    always_comb
    begin
        state_next     = state_reg;
        in_pos_next    = in_pos_reg;
        out_pos_next   = out_pos_reg;
        wr_addr_next   = wr_addr_reg;
        q_addr_next    = q_addr_reg;
        q_col_next     = q_col_reg;
        q_row_next     = q_row_reg;
        tj_next        = tj_reg;
        ti_next        = ti_reg;
        k_next         = k_reg;
        tr_next        = tr_reg;
        tc_next        = tc_reg;
        tc0_next       = tc0_reg;
        tap_addr_next  = tap_addr_reg;
        p_valid_next   = 1'b0;
        p_inb_next     = p_inb_reg;
        p_coef_next    = p_coef_reg;
        acc_next       = acc_reg;
        res_valid_next = res_valid_reg && !res_ready;
        value_next     = value_reg;
        col_next       = col_reg;
        row_next       = row_reg;
        last_next      = last_reg;

        // The tap read in the previous cycle returns now and is weighed into the sum.
        if (p_valid_reg)
        begin
            acc_next = acc_reg + SUM_W'(16'(p_coef_reg) * 16'(p_inb_reg ? rd_data : 8'd0));
        end

        case (state_reg)
            S_IDLE:
            begin
                if (pix_acc)
                begin
                    in_pos_next  = ip_n;
                    out_pos_next = op;
                    wr_addr_next = mem_we ? ring_inc(wa) : wa;
                    q_addr_next  = qa;
                    q_col_next   = qc;
                    q_row_next   = qr;
                    if (win_ready)
                    begin
                        state_next    = S_GATHER;
                        tj_next       = '0;
                        ti_next       = '0;
                        k_next        = '0;
                        tr_next       = $signed(TRW'(qr)) - $signed(TRW'(half_reg));
                        tc_next       = $signed(TCW'(qc)) - $signed(TCW'(half_reg));
                        tc0_next      = $signed(TCW'(qc)) - $signed(TCW'(half_reg));
                        tap_addr_next = fold_addr($signed(SAW'(qa)) - $signed(SAW'(lead_reg)));
                        acc_next      = '0;
                    end
                end
            end
            S_GATHER:
            begin
                p_valid_next = 1'b1;
                p_inb_next   = tap_inb;
                p_coef_next  = coef_reg[k_reg * ggc_pkg::COEF_W +: ggc_pkg::COEF_W];
                k_next       = k_reg + 1'b1;
                if (last_tap)
                begin
                    state_next = S_FLUSH;
                end
                else if (ti_reg == side_reg - 3'd1)
                begin
                    ti_next       = '0;
                    tj_next       = tj_reg + 3'd1;
                    tc_next       = tc0_reg;
                    tr_next       = tr_reg + 1'b1;
                    tap_addr_next = fold_addr($signed(SAW'(tap_addr_reg))
                                    + $signed(SAW'(eff_w_reg)) - $signed(SAW'(side_reg))
                                    + SAW'(1));
                end
                else
                begin
                    ti_next       = ti_reg + 3'd1;
                    tc_next       = tc_reg + 1'b1;
                    tap_addr_next = ring_inc(tap_addr_reg);
                end
            end
            S_FLUSH:
            begin
                state_next = S_DIVIDE;
            end
            S_DIVIDE:
            begin
                if (div_done)
                begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (!res_valid_reg || res_ready)
                begin
                    state_next     = S_IDLE;
                    res_valid_next = 1'b1;
                    value_next     = (quotient > SUM_W'(255)) ? 8'd255 : quotient[7:0];
                    col_next       = 11'(q_col_reg);
                    row_next       = 12'(q_row_reg);
                    last_next      = (out_pos_reg + 1'b1 == total_reg);
                    if (out_pos_reg + 1'b1 >= total_reg)
                    begin
                        in_pos_next  = '0;
                        out_pos_next = '0;
                        wr_addr_next = '0;
                        q_addr_next  = '0;
                        q_col_next   = '0;
                        q_row_next   = '0;
                    end
                    else
                    begin
                        out_pos_next = out_pos_reg + 1'b1;
                        q_addr_next  = ring_inc(q_addr_reg);
                        if (WW'(q_col_reg) + WW'(1) == eff_w_reg)
                        begin
                            q_col_next = '0;
                            q_row_next = q_row_reg + 1'b1;
                        end
                        else
                        begin
                            q_col_next = q_col_reg + 1'b1;
                        end
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            in_pos_reg    <= '0;
            out_pos_reg   <= '0;
            wr_addr_reg   <= '0;
            q_addr_reg    <= '0;
            q_col_reg     <= '0;
            q_row_reg     <= '0;
            p_valid_reg   <= 1'b0;
            res_valid_reg <= 1'b0;
            tj_reg        <= '0;
            ti_reg        <= '0;
            k_reg         <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            in_pos_reg    <= in_pos_next;
            out_pos_reg   <= out_pos_next;
            wr_addr_reg   <= wr_addr_next;
            q_addr_reg    <= q_addr_next;
            q_col_reg     <= q_col_next;
            q_row_reg     <= q_row_next;
            p_valid_reg   <= p_valid_next;
            res_valid_reg <= res_valid_next;
            tj_reg        <= tj_next;
            ti_reg        <= ti_next;
            k_reg         <= k_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tr_reg       <= tr_next;
        tc_reg       <= tc_next;
        tc0_reg      <= tc0_next;
        tap_addr_reg <= tap_addr_next;
        p_inb_reg    <= p_inb_next;
        p_coef_reg   <= p_coef_next;
        acc_reg      <= acc_next;
        value_reg    <= value_next;
        col_reg      <= col_next;
        row_reg      <= row_next;
        last_reg     <= last_next;
    end

    // Writes happen only in the accepting cycle and reads start after it, so a tap
    // never meets a write to its own entry in flight.
    ggc_ram #(
        .WIDTH (8),
        .DEPTH (LINE_DEPTH)
    ) u_line_store (
        .clk     (clk),
        .we      (mem_we),
        .wr_addr (wa),
        .wr_data (grey),
        .rd_en   (state_reg == S_GATHER),
        .rd_addr (tap_addr_reg),
        .rd_data (rd_data)
    );

    // The last product lands in the flush cycle, so the divider takes the sum with it.
    ggc_divider #(
        .DW (SUM_W),
        .VW (ggc_pkg::DIV_W)
    ) u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (state_reg == S_FLUSH),
        .dividend (acc_next),
        .divisor  (div_reg),
        .done     (div_done),
        .quotient (quotient)
    );

    assign pix_ready     = (state_reg == S_IDLE) && !cfg_we && (cfg_settle_reg == 2'd0);
    assign res_valid     = res_valid_reg;
    assign blurred_value = value_reg;
    assign out_col       = col_reg;
    assign out_row       = row_reg;
    assign last_pixel    = last_reg;

`ifndef SYNTH
    // The divider only finishes while the block waits for it.
    assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == S_DIVIDE))
        else $error("divider finished outside the divide phase");

    // An output is only produced for a position whose pixel has been accepted.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EMIT) |-> (out_pos_reg < in_pos_reg))
        else $error("output position overtook input position");

    // The tap walk never runs past the last coefficient.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_GATHER) |-> (32'(k_reg) < ggc_pkg::NUM_COEF))
        else $error("tap index beyond coefficient store");

    // Every gathered tap is followed by its product on the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_GATHER) |=> p_valid_reg)
        else $error("tap read lost its product stage");
`endif

endmodule

// ----- tb/tb.sv -----
// Self-checking testbench for grey_gaussian_convolution: directed table, directed corner cases, then random images.
// Depends on ggc_pkg and the RTL top level; carries its own bit-accurate filter predictor.
`timescale 1ns / 100ps

module tb;

    localparam int LINE_DEPTH = ggc_pkg::MAX_SIDE_DEF * ggc_pkg::MAX_WIDTH_DEF;
    // Worst beat: the gather over 25 taps, the flush, the divider and the emit, plus margin.
    localparam int BEAT_LATENCY = 60;
    localparam int WATCHDOG_LIMIT = 2000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic pix_valid = 1'b0;
    logic pix_ready;
    logic action = 1'b0;
    logic [7:0] red = '0, green = '0, blue = '0;
    logic res_valid;
    logic res_ready = 1'b0;
    logic [7:0] blurred_value;
    logic [10:0] out_col;
    logic [11:0] out_row;
    logic last_pixel;
    logic cfg_we = 1'b0;
    logic [2:0] cfg_index = ggc_pkg::REG_IMAGE_WIDTH;
    logic [ggc_pkg::CFG_W-1:0] cfg_data = '0;

    always #10 clk = ~clk;

    grey_gaussian_convolution u_top (
        .clk(clk), .rst_n(rst_n),
        .pix_valid(pix_valid), .pix_ready(pix_ready),
        .action(action), .red(red), .green(green), .blue(blue),
        .res_valid(res_valid), .res_ready(res_ready),
        .blurred_value(blurred_value), .out_col(out_col), .out_row(out_row),
        .last_pixel(last_pixel),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    typedef struct packed {
        logic [7:0]  value;
        logic [10:0] col;
        logic [11:0] row;
        logic        last;
    } blur_result_t;

    typedef struct {
        logic        drain;
        logic [7:0]  r, g, b;
        logic        known;      // expected value typed into the table
        logic [7:0]  known_value;
    } pixel_row_t;

    // Predictor state, mirroring the block's registers and stores.
    logic [11:0] width_reg;
    logic [12:0] height_reg;
    logic [2:0]  side_reg;
    logic [15:0] divisor_reg;
    logic [7:0]  coef [ggc_pkg::NUM_COEF];
    logic [7:0]  grey_lines [LINE_DEPTH];
    int unsigned pix_count, out_count;

    blur_result_t pending_results[$];
    int errors = 0;
    int beats_in = 0, results_seen = 0;
    int idle_cycles = 0;
    int max_res_wait = 14;

    function automatic int unsigned eff_width();
        int unsigned w;
        w = width_reg;
        if (w == 0) w = 1;
        if (w > ggc_pkg::MAX_WIDTH_DEF) w = ggc_pkg::MAX_WIDTH_DEF;
        return w;
    endfunction

    function automatic int unsigned eff_height();
        int unsigned h;
        h = height_reg;
        if (h == 0) h = 1;
        if (h > ggc_pkg::MAX_HEIGHT_DEF) h = ggc_pkg::MAX_HEIGHT_DEF;
        return h;
    endfunction

    function automatic int unsigned eff_side();
        int unsigned s;
        s = side_reg;
        if (s > ggc_pkg::MAX_SIDE_DEF) s = ggc_pkg::MAX_SIDE_DEF;
        if (s == 0) s = 1;
        if (s[0] == 1'b0) s = s - 1;
        return s;
    endfunction

    // Writes one register while the pixel side is idle.
    task automatic write_reg(input logic [2:0] idx, input logic [ggc_pkg::CFG_W-1:0] data);
        pix_valid <= 1'b0;
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            ggc_pkg::REG_IMAGE_WIDTH:   width_reg = data[11:0];
            ggc_pkg::REG_IMAGE_HEIGHT:  height_reg = data[12:0];
            ggc_pkg::REG_KERNEL_SIDE:   side_reg = data[2:0];
            ggc_pkg::REG_SCALE_DIVISOR: divisor_reg = data[15:0];
            ggc_pkg::REG_COEF_BANK0:    for (int k = 0; k < 8; k++) coef[k] = data[8*k +: 8];
            ggc_pkg::REG_COEF_BANK1:    for (int k = 0; k < 8; k++) coef[8+k] = data[8*k +: 8];
            ggc_pkg::REG_COEF_BANK2:    for (int k = 0; k < 8; k++) coef[16+k] = data[8*k +: 8];
            default:                    coef[24] = data[7:0];
        endcase
    endtask

    // Weighted, zero-padded window sum at raster position q, scaled and clipped.
    function automatic logic [7:0] blur_at(int unsigned q, int unsigned w, int unsigned ht,
                                           int unsigned side);
        int rr, cc, half, row, col;
        int unsigned sum, dv;
        half = side / 2;
        row = q / w;
        col = q % w;
        sum = 0;
        for (int j = 0; j < side; j++)
        begin
            rr = row + j - half;
            if (rr < 0 || rr >= ht) continue;
            for (int i = 0; i < side; i++)
            begin
                cc = col + i - half;
                if (cc < 0 || cc >= w) continue;
                sum += coef[j*side + i] * grey_lines[(rr*w + cc) % LINE_DEPTH];
            end
        end
        dv = (divisor_reg == 0) ? 1 : divisor_reg;
        sum = sum / dv;
        return (sum > 255) ? 8'd255 : sum[7:0];
    endfunction

    // Advances the predictor by one accepted beat; returns 1 when a result is due.
    function automatic bit predict_beat(input logic drain, input logic [7:0] r, g, b,
                                        output blur_result_t res);
        int unsigned w, ht, side, total, half, q;
        w = eff_width();
        ht = eff_height();
        side = eff_side();
        total = w * ht;
        half = side / 2;
        res = '0;
        if (out_count >= total || pix_count > total)
        begin
            pix_count = 0;
            out_count = 0;
        end
        if (!drain)
        begin
            if (pix_count >= total) return 0;
            grey_lines[pix_count % LINE_DEPTH] = 8'((r + g + b) / 3);
            pix_count++;
        end
        q = out_count;
        if (!(pix_count >= total || pix_count > q + half*w + half)) return 0;
        res.value = blur_at(q, w, ht, side);
        res.col = 11'(q % w);
        res.row = 12'(q / w);
        res.last = (q + 1 == total);
        out_count++;
        if (out_count >= total)
        begin
            pix_count = 0;
            out_count = 0;
        end
        return 1;
    endfunction

    // Drives one beat and waits for acceptance; the expectation is queued at acceptance.
    // Valid stays up after acceptance and is lowered by the next idle gap, writer or idle wait.
    task automatic send_beat(input logic drain, input logic [7:0] r, g, b,
                             input logic known, input logic [7:0] known_value,
                             input bit gaps);
        blur_result_t res;
        int wait_n;
        wait_n = gaps ? $urandom_range(0, 14) : 0;
        if (wait_n > 0)
        begin
            pix_valid <= 1'b0;
            repeat (wait_n) @(posedge clk);
        end
        pix_valid <= 1'b1;
        action <= drain;
        red <= r;
        green <= g;
        blue <= b;
        do @(posedge clk); while (!pix_ready);
        beats_in++;
        if (predict_beat(drain, r, g, b, res))
        begin
            if (known && res.value !== known_value)
            begin
                errors++;
                if (errors <= 10)
                    $display("table entry mismatch: expected %0d predicted %0d",
                             known_value, res.value);
            end
            pending_results.push_back(res);
        end
    endtask

    // Waits until every queued result has arrived, then lets the block settle.
    task automatic wait_idle();
        pix_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (BEAT_LATENCY) @(posedge clk);
    endtask

    // Result side: random stalls and field-by-field comparison.
    initial
    begin : result_sink
        int stall;
        blur_result_t want;
        forever
        begin
            stall = $urandom_range(0, max_res_wait);
            if (stall > 0)
            begin
                res_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            res_ready <= 1'b1;
            do @(posedge clk); while (!res_valid);
            results_seen++;
            if (pending_results.size() == 0)
            begin
                errors++;
                if (errors <= 10) $display("unexpected result beat at row %0d col %0d",
                                           out_row, out_col);
            end
            else
            begin
                want = pending_results.pop_front();
                if (blurred_value !== want.value || out_col !== want.col ||
                    out_row !== want.row || last_pixel !== want.last)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("mismatch: expected v=%0d c=%0d r=%0d l=%0d, got v=%0d c=%0d r=%0d l=%0d",
                                 want.value, want.col, want.row, want.last,
                                 blurred_value, out_col, out_row, last_pixel);
                end
            end
        end
    end

    // Watchdog on cycles with no accepted beat on either channel.
    always @(posedge clk)
    begin
        if ((pix_valid && pix_ready) || (res_valid && res_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog expired");
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Sends a whole image of random pixels, with occasional drains, plus flushing drains.
    task automatic random_image(input int noise_pct);
        int unsigned total;
        total = eff_width() * eff_height();
        for (int p = 0; p < total; p++)
        begin
            if ($urandom_range(0, 99) < noise_pct)
                send_beat(1'b1, $urandom, $urandom, $urandom, 1'b0, 8'd0, 1'b1);
            send_beat(1'b0, $urandom, $urandom, $urandom, 1'b0, 8'd0, $urandom_range(0, 3) != 0);
        end
        while (out_count != 0 || pix_count != 0)
            send_beat(1'b1, $urandom, $urandom, $urandom, 1'b0, 8'd0, 1'b1);
    endtask

    task automatic random_coefs();
        write_reg(ggc_pkg::REG_COEF_BANK0, {$urandom, $urandom});
        write_reg(ggc_pkg::REG_COEF_BANK1, {$urandom, $urandom});
        write_reg(ggc_pkg::REG_COEF_BANK2, {$urandom, $urandom});
        write_reg(ggc_pkg::REG_COEF_BANK3, $urandom);
    endtask

    pixel_row_t directed [] = '{
        // Identity 1x1 on a 1x1 image: grey of the pixel.
        '{1'b0, 8'd0,   8'd0,   8'd0,   1'b1, 8'd0},
        '{1'b0, 8'd255, 8'd255, 8'd255, 1'b1, 8'd255},
        '{1'b0, 8'd255, 8'd255, 8'd254, 1'b1, 8'd254},
        '{1'b0, 8'd1,   8'd1,   8'd0,   1'b1, 8'd0},
        '{1'b0, 8'd170, 8'd85,  8'd0,   1'b1, 8'd85},
        // A drain with nothing pending gives no result.
        '{1'b1, 8'hAA,  8'h55,  8'hFF,  1'b0, 8'd0}
    };

    initial
    begin : stimulus
        width_reg = 1; height_reg = 1; side_reg = 1; divisor_reg = 1;
        for (int k = 0; k < ggc_pkg::NUM_COEF; k++) coef[k] = (k == 0);
        for (int k = 0; k < LINE_DEPTH; k++) grey_lines[k] = '0;
        pix_count = 0;
        out_count = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table at reset settings.
        foreach (directed[n])
            send_beat(directed[n].drain, directed[n].r, directed[n].g, directed[n].b,
                      directed[n].known, directed[n].known_value, 1'b0);
        wait_idle();

        // Extreme coefficients and a 5x5 kernel on a 4x3 image: clip at 255, drains early.
        write_reg(ggc_pkg::REG_IMAGE_WIDTH, 4);
        write_reg(ggc_pkg::REG_IMAGE_HEIGHT, 3);
        write_reg(ggc_pkg::REG_KERNEL_SIDE, 5);
        write_reg(ggc_pkg::REG_SCALE_DIVISOR, 1);
        write_reg(ggc_pkg::REG_COEF_BANK0, '1);
        write_reg(ggc_pkg::REG_COEF_BANK1, '1);
        write_reg(ggc_pkg::REG_COEF_BANK2, '1);
        write_reg(ggc_pkg::REG_COEF_BANK3, 8'hFF);
        send_beat(1'b1, 0, 0, 0, 1'b0, 0, 1'b0);     // drain before any window completes
        for (int p = 0; p < 12; p++)
            send_beat(1'b0, 8'd255, 8'd255, 8'd255, 1'b0, 0, 1'b0);
        send_beat(1'b0, 8'd9, 8'd9, 8'd9, 1'b0, 0, 1'b0);   // pixel past image end
        while (out_count != 0 || pix_count != 0) send_beat(1'b1, 0, 0, 0, 1'b0, 0, 1'b0);
        wait_idle();

        // Odd register values: zero and oversized sizes, even side, zero divisor.
        write_reg(ggc_pkg::REG_IMAGE_WIDTH, 0);
        write_reg(ggc_pkg::REG_IMAGE_HEIGHT, 0);
        write_reg(ggc_pkg::REG_KERNEL_SIDE, 4);
        write_reg(ggc_pkg::REG_SCALE_DIVISOR, 0);
        random_image(0);
        wait_idle();
        write_reg(ggc_pkg::REG_KERNEL_SIDE, 7);
        write_reg(ggc_pkg::REG_IMAGE_WIDTH, 12'hFFF);
        write_reg(ggc_pkg::REG_IMAGE_HEIGHT, 1);
        write_reg(ggc_pkg::REG_SCALE_DIVISOR, 16'hFFFF);
        send_beat(1'b0, 8'd255, 8'd255, 8'd255, 1'b0, 0, 1'b0);
        // Shrinking the image mid-stream: the next pixel finds the image already full.
        write_reg(ggc_pkg::REG_IMAGE_WIDTH, 1);
        write_reg(ggc_pkg::REG_KERNEL_SIDE, 1);
        send_beat(1'b0, 8'd30, 8'd60, 8'd90, 1'b0, 0, 1'b0);
        wait_idle();

        // Random images: mostly small sizes, then one wider two-row image.
        while (beats_in < 900)
        begin
            write_reg(ggc_pkg::REG_IMAGE_WIDTH, $urandom_range(1, 9));
            write_reg(ggc_pkg::REG_IMAGE_HEIGHT, $urandom_range(1, 8));
            write_reg(ggc_pkg::REG_KERNEL_SIDE, $urandom_range(0, 7));
            write_reg(ggc_pkg::REG_SCALE_DIVISOR, ($urandom_range(0, 3) == 0) ? $urandom
                                                                    : $urandom_range(1, 400));
            random_coefs();
            max_res_wait = ($urandom_range(0, 3) == 0) ? 0 : 14;
            random_image(($urandom_range(0, 4) == 0) ? 20 : 0);
            wait_idle();
        end
        write_reg(ggc_pkg::REG_IMAGE_WIDTH, 128);
        write_reg(ggc_pkg::REG_IMAGE_HEIGHT, 2);
        write_reg(ggc_pkg::REG_KERNEL_SIDE, 5);
        write_reg(ggc_pkg::REG_SCALE_DIVISOR, 64);
        random_coefs();
        max_res_wait = 14;
        random_image(0);

        wait_idle();
        $display("Covered %0d input beats and %0d result beats over many image sizes and kernels.",
                 beats_in, results_seen);
        if (errors == 0 && pending_results.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
